// ===== rtl/prc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package prc_pkg;

    // sample and store geometry
    localparam int SAMPLE_BITS   = 24;
    localparam int RING_DEPTH    = 4096;   // power of two, ring address is a bit slice
    localparam int CAPTURE_DEPTH = 8192;
    localparam int RING_AW       = $clog2(RING_DEPTH);
    localparam int CAP_AW        = $clog2(CAPTURE_DEPTH);
    localparam int CNT_W         = $clog2(CAPTURE_DEPTH + 1);
    localparam int LIM_W         = $clog2(RING_DEPTH + 1);
    localparam int IDX_W         = 13;
    localparam int CMP_W         = (IDX_W > LIM_W) ? IDX_W : LIM_W;
    localparam int SW_W          = 48;
    localparam int CMD_W         = 2;
    localparam int CC_W          = 2;
    localparam int STATE_W       = 2;

    typedef enum logic [CMD_W-1:0] {
        CMD_PUSH    = 2'd0,
        CMD_TRIGGER = 2'd1,
        CMD_READ    = 2'd2,
        CMD_RESET   = 2'd3
    } cmd_t;

    typedef enum logic [STATE_W-1:0] {
        MODE_MON  = 2'd0,
        MODE_REC  = 2'd1,
        MODE_DONE = 2'd2
    } mode_t;

    // controller to datapath
    typedef struct packed {
        logic accept;     // input beat taken this cycle
        logic walk;       // one pretrigger copy step
        logic load_out;   // load the result register
    } prc_ctl_t;

    // datapath to controller
    typedef struct packed {
        cmd_t command;
        logic pre_zero;
        logic post_zero;
        logic walk_last;
    } prc_sts_t;

endpackage

`default_nettype wire

// ===== rtl/prc_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface prc_item_if;
    import prc_pkg::*;

    logic                          valid;
    logic                          ready;
    logic [CMD_W-1:0]              command;
    logic signed [SAMPLE_BITS-1:0] left_sample;
    logic signed [SAMPLE_BITS-1:0] right_sample;
    logic                          block_start;
    logic [IDX_W-1:0]              pre_count;
    logic [IDX_W-1:0]              post_count;
    logic [IDX_W-1:0]              read_index;

    modport source (
        output valid, command, left_sample, right_sample, block_start,
               pre_count, post_count, read_index,
        input  ready
    );

    modport sink (
        input  valid, command, left_sample, right_sample, block_start,
               pre_count, post_count, read_index,
        output ready
    );
endinterface

interface prc_result_if;
    import prc_pkg::*;

    logic                          valid;
    logic                          ready;
    logic                          trigger_ok;
    logic [STATE_W-1:0]            capture_state;
    logic [SAMPLE_BITS-1:0]        peak_level;
    logic [CNT_W-1:0]              captured_length;
    logic signed [SAMPLE_BITS-1:0] read_value;
    logic                          read_valid;

    modport source (
        output valid, trigger_ok, capture_state, peak_level, captured_length,
               read_value, read_valid,
        input  ready
    );

    modport sink (
        input  valid, trigger_ok, capture_state, peak_level, captured_length,
               read_value, read_valid,
        output ready
    );
endinterface

`default_nettype wire

// ===== rtl/prc_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none

module prc_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               item_valid,
    input  logic               result_ready,
    input  prc_pkg::prc_sts_t  sts,
    output logic               item_ready,
    output logic               result_valid,
    output prc_pkg::prc_ctl_t  ctl
);
    import prc_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_WALK  = 4'b0010,
        ST_FLUSH = 4'b0100,
        ST_RESP  = 4'b1000
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_vld_reg;
    logic   out_vld_next;
    logic   slot_free;
    logic   accept;
    logic   walk;
    logic   load_out;

    assign slot_free = !out_vld_reg || result_ready;

    always_comb
    begin
        state_next = state_reg;
        item_ready = 1'b0;
        accept     = 1'b0;
        walk       = 1'b0;
        load_out   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                item_ready = slot_free;
                if (item_valid && slot_free)
                begin
                    accept = 1'b1;
                    case (sts.command)
                        CMD_READ:
                        begin
                            state_next = ST_RESP;
                        end
                        CMD_TRIGGER:
                        begin
                            if (!sts.post_zero && !sts.pre_zero)
                                state_next = ST_WALK;
                            else
                                load_out = 1'b1;
                        end
                        default:
                        begin
                            load_out = 1'b1;
                        end
                    endcase
                end
            end
            ST_WALK:
            begin
                walk = 1'b1;
                if (sts.walk_last)
                    state_next = ST_FLUSH;
            end
            ST_FLUSH:
            begin
                state_next = ST_RESP;
            end
            ST_RESP:
            begin
                if (slot_free)
                begin
                    load_out   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (load_out)
            out_vld_next = 1'b1;
        else if (result_ready)
            out_vld_next = 1'b0;
        else
            out_vld_next = out_vld_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            out_vld_reg <= out_vld_next;
        end
    end

    assign result_valid = out_vld_reg;
    assign ctl.accept   = accept;
    assign ctl.walk     = walk;
    assign ctl.load_out = load_out;

endmodule

`default_nettype wire

// ===== rtl/prc_dp.sv =====
`timescale 1ns / 1ps
`default_nettype none

module prc_dp (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   cfg_wr_en,
    input  logic [prc_pkg::CC_W-1:0]               cfg_wr_data,
    input  prc_pkg::prc_ctl_t                      ctl,
    output prc_pkg::prc_sts_t                      sts,
    input  logic [prc_pkg::CMD_W-1:0]              command,
    input  logic signed [prc_pkg::SAMPLE_BITS-1:0] left_sample,
    input  logic signed [prc_pkg::SAMPLE_BITS-1:0] right_sample,
    input  logic                                   block_start,
    input  logic [prc_pkg::IDX_W-1:0]              pre_count,
    input  logic [prc_pkg::IDX_W-1:0]              post_count,
    input  logic [prc_pkg::IDX_W-1:0]              read_index,
    output logic                                   trigger_ok,
    output logic [prc_pkg::STATE_W-1:0]            capture_state,
    output logic [prc_pkg::SAMPLE_BITS-1:0]        peak_level,
    output logic [prc_pkg::CNT_W-1:0]              captured_length,
    output logic signed [prc_pkg::SAMPLE_BITS-1:0] read_value,
    output logic                                   read_valid
);
    import prc_pkg::*;

    localparam int SB = SAMPLE_BITS;

    logic [SB-1:0] ring_mem [RING_DEPTH];
    logic [SB-1:0] cap_mem  [CAPTURE_DEPTH];

    // control and counters
    logic [CC_W-1:0]    cc_reg;
    logic [SW_W-1:0]    sw_reg;
    logic [SW_W-1:0]    sw_next;
    logic [IDX_W-1:0]   post_left_reg;
    logic [IDX_W-1:0]   post_left_next;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;
    mode_t              mode_reg;
    mode_t              mode_next;
    logic [SB-1:0]      peak_reg;
    logic [SB-1:0]      peak_next;
    logic [IDX_W-1:0]   back_reg;
    logic [RING_AW-1:0] rp_reg;
    logic [LIM_W-1:0]   lim_reg;
    logic               wpend_reg;
    logic               hit_reg;
    logic               ok_reg;
    logic               rd_hit_reg;

    // memory read data
    logic [SB-1:0]      ring_q_reg;
    logic [SB-1:0]      cap_q_reg;

    // result register
    logic               trigger_ok_reg;
    logic [STATE_W-1:0] state_out_reg;
    logic [SB-1:0]      peak_out_reg;
    logic [CNT_W-1:0]   len_out_reg;
    logic [SB-1:0]      rval_out_reg;
    logic               rvalid_out_reg;

    cmd_t               cmd;
    logic               is_push;
    logic               is_trig;
    logic               is_read;
    logic               is_reset;
    logic               trig_ok;
    logic               rd_hit;
    logic [SB:0]        l_ext;
    logic [SB:0]        r_ext;
    logic [SB:0]        sum;
    logic [SB-1:0]      mono;
    logic [SB:0]        abs_l_w;
    logic [SB:0]        abs_r_w;
    logic [SB-1:0]      abs_l;
    logic [SB-1:0]      abs_r;
    logic [SB-1:0]      peak_base;
    logic [SB-1:0]      peak_1;
    logic [SB-1:0]      peak_2;
    logic               record;
    logic               cap_room;
    logic               cap_we;
    logic [SB-1:0]      cap_wdata;

    assign cmd      = cmd_t'(command);
    assign is_push  = ctl.accept && (cmd == CMD_PUSH);
    assign is_trig  = ctl.accept && (cmd == CMD_TRIGGER);
    assign is_read  = ctl.accept && (cmd == CMD_READ);
    assign is_reset = ctl.accept && (cmd == CMD_RESET);
    assign trig_ok  = is_trig && (post_count != '0);
    assign rd_hit   = CNT_W'(read_index) < count_reg;

    // mono sample: floored average, right copies left in mono mode
    assign l_ext = {left_sample[SB-1], left_sample};
    assign r_ext = cc_reg[1] ? {right_sample[SB-1], right_sample} : l_ext;
    assign sum   = l_ext + r_ext;
    assign mono  = sum[SB:1];

    assign abs_l_w = l_ext[SB] ? (~l_ext + (SB+1)'(1)) : l_ext;
    assign abs_r_w = r_ext[SB] ? (~r_ext + (SB+1)'(1)) : r_ext;
    assign abs_l   = abs_l_w[SB-1:0];
    assign abs_r   = abs_r_w[SB-1:0];

    assign peak_base = block_start ? '0 : peak_reg;
    assign peak_1    = (abs_l > peak_base) ? abs_l : peak_base;
    assign peak_2    = (abs_r > peak_1) ? abs_r : peak_1;

    assign record    = is_push && (mode_reg == MODE_REC) && (post_left_reg != '0);
    assign cap_room  = count_reg < CNT_W'(CAPTURE_DEPTH);
    assign cap_we    = (record || wpend_reg) && cap_room;
    assign cap_wdata = wpend_reg ? (hit_reg ? ring_q_reg : '0) : mono;

    always_comb
    begin
        sw_next        = sw_reg;
        post_left_next = post_left_reg;
        count_next     = count_reg;
        mode_next      = mode_reg;
        peak_next      = peak_reg;
        if (is_push)
        begin
            peak_next = peak_2;
            sw_next   = sw_reg + SW_W'(1);
        end
        if (record)
        begin
            post_left_next = post_left_reg - IDX_W'(1);
            if (post_left_reg == IDX_W'(1))
                mode_next = MODE_DONE;
        end
        if (cap_we)
            count_next = count_reg + CNT_W'(1);
        if (trig_ok)
        begin
            count_next     = '0;
            post_left_next = post_count;
            mode_next      = MODE_REC;
        end
        if (is_reset)
        begin
            sw_next        = '0;
            post_left_next = '0;
            count_next     = '0;
            mode_next      = MODE_MON;
            peak_next      = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cc_reg        <= CC_W'(2);
            sw_reg        <= '0;
            post_left_reg <= '0;
            count_reg     <= '0;
            mode_reg      <= MODE_MON;
            peak_reg      <= '0;
            back_reg      <= '0;
            wpend_reg     <= 1'b0;
            ok_reg        <= 1'b0;
            rd_hit_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
                cc_reg <= cfg_wr_data;
            sw_reg        <= sw_next;
            post_left_reg <= post_left_next;
            count_reg     <= count_next;
            mode_reg      <= mode_next;
            peak_reg      <= peak_next;
            wpend_reg     <= ctl.walk;
            if (ctl.accept)
            begin
                ok_reg     <= trig_ok;
                rd_hit_reg <= is_read && rd_hit;
            end
            if (trig_ok)
                back_reg <= pre_count;
            else if (ctl.walk)
                back_reg <= back_reg - IDX_W'(1);
        end
    end

    // walk pointers, entry valid while the look-back distance stays in range
    always_ff @(posedge clk)
    begin
        if (trig_ok)
        begin
            rp_reg <= sw_reg[RING_AW-1:0] - pre_count[RING_AW-1:0];
            if (|sw_reg[SW_W-1:RING_AW])
                lim_reg <= LIM_W'(RING_DEPTH);
            else
                lim_reg <= LIM_W'(sw_reg[RING_AW-1:0]);
        end
        else if (ctl.walk)
        begin
            rp_reg <= rp_reg + RING_AW'(1);
        end
        if (ctl.walk)
            hit_reg <= CMP_W'(back_reg) <= CMP_W'(lim_reg);
    end

    always_ff @(posedge clk)
    begin
        if (is_push)
            ring_mem[sw_reg[RING_AW-1:0]] <= mono;
        if (ctl.walk)
            ring_q_reg <= ring_mem[rp_reg];
    end

    always_ff @(posedge clk)
    begin
        if (cap_we)
            cap_mem[count_reg[CAP_AW-1:0]] <= cap_wdata;
        if (is_read)
            cap_q_reg <= cap_mem[read_index[CAP_AW-1:0]];
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load_out)
        begin
            trigger_ok_reg <= ctl.accept ? trig_ok : ok_reg;
            state_out_reg  <= mode_next;
            peak_out_reg   <= peak_next;
            len_out_reg    <= count_next;
            rvalid_out_reg <= !ctl.accept && rd_hit_reg;
            rval_out_reg   <= (!ctl.accept && rd_hit_reg) ? cap_q_reg : '0;
        end
    end

    assign sts.command   = cmd;
    assign sts.pre_zero  = (pre_count == '0);
    assign sts.post_zero = (post_count == '0);
    assign sts.walk_last = (back_reg == IDX_W'(1));

    assign trigger_ok      = trigger_ok_reg;
    assign capture_state   = state_out_reg;
    assign peak_level      = peak_out_reg;
    assign captured_length = len_out_reg;
    assign read_value      = rval_out_reg;
    assign read_valid      = rvalid_out_reg;

endmodule

`default_nettype wire

// ===== rtl/pretrigger_ring_capture.sv =====
`timescale 1ns / 1ps
`default_nettype none

// channel   dir   handshake        beat contents
// item      in    valid / ready    command, left/right sample, block_start,
//                                  pre_count, post_count, read_index
// result    out   valid / ready    trigger_ok, capture_state, peak_level,
//                                  captured_length, read_value, read_valid
// cfg       in    cfg_wr_en        cfg_wr_data -> channel_count
//
// push, reset and a trigger with no look-back (or a rejected one) load the result in the accept cycle
// read goes through one registered read of the capture memory before the result is loaded
// accepted trigger copies pre_count ring entries, one ring memory read per copied entry
// rst_n clears counters, mode and peak at once; memories need no clearing pass
// a stalled result holds the item channel off until the result register frees up

module pretrigger_ring_capture (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_wr_en,
    input  logic [prc_pkg::CC_W-1:0]    cfg_wr_data,
    prc_item_if.sink                    item,
    prc_result_if.source                result
);
    import prc_pkg::*;

    // command and status between controller and datapath
    prc_ctl_t ctl;
    prc_sts_t sts;
    logic     item_ready;
    logic     result_valid;

    // controller: one-hot sequencer for accept, pretrigger walk and response
    prc_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item.valid),
        .result_ready (result.ready),
        .sts          (sts),
        .item_ready   (item_ready),
        .result_valid (result_valid),
        .ctl          (ctl)
    );

    // datapath: ring and capture memories, counters, peak tracker, result register
    prc_dp u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_wr_data     (cfg_wr_data),
        .ctl             (ctl),
        .sts             (sts),
        .command         (item.command),
        .left_sample     (item.left_sample),
        .right_sample    (item.right_sample),
        .block_start     (item.block_start),
        .pre_count       (item.pre_count),
        .post_count      (item.post_count),
        .read_index      (item.read_index),
        .trigger_ok      (result.trigger_ok),
        .capture_state   (result.capture_state),
        .peak_level      (result.peak_level),
        .captured_length (result.captured_length),
        .read_value      (result.read_value),
        .read_valid      (result.read_valid)
    );

    // handshake outputs
    assign item.ready   = item_ready;
    assign result.valid = result_valid;

endmodule

`default_nettype wire

// ===== rtl/prc_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

module prc_checker (
    input logic                                   clk,
    input logic                                   rst_n,
    input logic                                   item_valid,
    input logic                                   item_ready,
    input logic [prc_pkg::CMD_W-1:0]              command,
    input logic [prc_pkg::IDX_W-1:0]              pre_count,
    input logic [prc_pkg::IDX_W-1:0]              post_count,
    input logic                                   result_valid,
    input logic                                   result_ready,
    input logic                                   trigger_ok,
    input logic [prc_pkg::STATE_W-1:0]            capture_state,
    input logic [prc_pkg::SAMPLE_BITS-1:0]        peak_level,
    input logic [prc_pkg::CNT_W-1:0]              captured_length,
    input logic signed [prc_pkg::SAMPLE_BITS-1:0] read_value,
    input logic                                   read_valid
);
    import prc_pkg::*;

    // push, reset and triggers that skip the walk answer on the next edge
    a_fast_resp: assert property (@(posedge clk) disable iff (!rst_n)
        (item_valid && item_ready && (command != CMD_READ)
         && !((command == CMD_TRIGGER) && (post_count != '0) && (pre_count != '0)))
        |=> result_valid)
    else $error("single-cycle command gave no result beat");

    // an accepted trigger always leaves the block recording
    a_trig_rec: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && trigger_ok) |-> (capture_state == MODE_REC))
    else $error("accepted trigger not in recording state");

    a_read_len: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && read_valid) |-> (captured_length != '0))
    else $error("valid read from empty capture");

    a_read_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !read_valid) |-> (read_value == '0))
    else $error("read value not zero without valid read");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !result_ready) |=>
        (result_valid && $stable(captured_length) && $stable(read_value)
         && $stable(peak_level)))
    else $error("stalled result beat changed");

endmodule

bind pretrigger_ring_capture prc_checker u_prc_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .item_valid      (item.valid),
    .item_ready      (item.ready),
    .command         (item.command),
    .pre_count       (item.pre_count),
    .post_count      (item.post_count),
    .result_valid    (result.valid),
    .result_ready    (result.ready),
    .trigger_ok      (result.trigger_ok),
    .capture_state   (result.capture_state),
    .peak_level      (result.peak_level),
    .captured_length (result.captured_length),
    .read_value      (result.read_value),
    .read_valid      (result.read_valid)
);

`default_nettype wire
